### sv/bxq_pkg.sv
// Shared types, constants and helpers for the binary trie XOR query block.
package bxq_pkg;

   localparam int KEY_BITS   = 32;
   localparam int NODES      = 4096;
   localparam int NODE_W     = 12;
   localparam int FREE_W     = 13;
   localparam int TALLY_W    = 16;
   localparam int LVL_W      = 5;
   localparam int MAX_VALUES = 65535;

   typedef enum logic [2:0] {
      FN_INSERT = 3'd0,
      FN_ERASE  = 3'd1,
      FN_MAX    = 3'd2,
      FN_MIN    = 3'd3,
      FN_COUNT  = 3'd4,
      FN_CLEAR  = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_ABSENT  = 2'd2,
      ST_EMPTY   = 2'd3
   } status_type;

   typedef struct packed {
      logic [NODE_W-1:0]  zero_child;
      logic [NODE_W-1:0]  one_child;
      logic [TALLY_W-1:0] tally;
   } node_rec_type;

   typedef struct packed {
      status_type          status;
      logic [KEY_BITS-1:0] xor_result;
      logic [TALLY_W-1:0]  match_count;
   } rsp_payload_type;

   function automatic logic [NODE_W-1:0] child_of(node_rec_type rec, logic b);
      return b ? rec.one_child : rec.zero_child;
   endfunction

   function automatic node_rec_type set_child(node_rec_type rec, logic b,
                                              logic [NODE_W-1:0] id);
      node_rec_type r;
      r = rec;
      if (b) begin
         r.one_child = id;
      end else begin
         r.zero_child = id;
      end
      return r;
   endfunction

endpackage

### sv/bxq_ram.sv
// Generic single-port RAM with registered read data.
module bxq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/bxq_rsp_reg.sv
// Result holding register on the response stream.
module bxq_rsp_reg (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  bxq_pkg::rsp_payload_type payload,
   output logic                     free,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [47:0]              rsp_tdata,
   output logic [1:0]               rsp_tuser
);
   import bxq_pkg::*;

   logic            valid_ff, valid_in;
   rsp_payload_type data_ff, data_in;

   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = payload;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {data_ff.match_count, data_ff.xor_result};
   assign rsp_tuser  = data_ff.status;

endmodule

### sv/binary_trie_xor_query.sv
// Insert walks the trie twice (check walk plus update walk); erase likewise.
// Max/min/count make a single walk from the root down the trie levels.
// One transaction at a time; node memory single port, one access per cycle sets the pace.
// Result held in an output register, so the next request is taken while it waits.
// Synchronous reset: empty store, root has no children, allocation starts at node 1.
// Clear acts the same; no memory sweep is needed.
module binary_trie_xor_query (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // key_value[31:0], limit[63:32]
   input  logic [2:0]  req_tuser,   // func[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // xor_result[31:0], match_count[47:32]
   output logic [1:0]  rsp_tuser    // status[1:0]
);
   import bxq_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_ICHK, S_ICHK_LD, S_IUPD, S_IUPD_LD, S_IUPD_NEW,
      S_ECHK, S_ECHK_LD, S_EUPD, S_EUPD_LD,
      S_XEVAL, S_XLD1, S_XLD2,
      S_CEVAL, S_CLD_T, S_CLD_N, S_DONE
   } state_type;

   state_type           state_ff, state_in;
   func_type            func_ff, func_in;
   logic [KEY_BITS-1:0] key_ff, key_in, lim_ff, lim_in;
   logic [NODE_W-1:0]   node_ff, node_in;
   node_rec_type        rec_ff, rec_in;
   logic [LVL_W-1:0]    lvl_ff, lvl_in;
   logic [FREE_W-1:0]   free_ff, free_in;
   logic [TALLY_W-1:0]  total_ff, total_in;
   logic [NODE_W-1:0]   root_zero_ff, root_zero_in, root_one_ff, root_one_in;
   logic [KEY_BITS-1:0] ans_ff, ans_in;
   logic [TALLY_W-1:0]  cnt_ff, cnt_in;
   status_type          stat_ff, stat_in;

   // node memory port
   logic                ram_we;
   logic [NODE_W-1:0]   ram_addr;
   node_rec_type        ram_wdata, q;
   logic [$bits(node_rec_type)-1:0] ram_rdata;

   logic            out_free, out_load;
   rsp_payload_type out_payload;

   logic              req_fire, bit_b, lim_b, first, lvl_last, alloc_ok;
   logic [NODE_W-1:0] c_b, c_nb, c_first, c_alt;
   logic [LVL_W:0]    need;
   func_type          req_func;
   node_rec_type      root_rec, new_rec;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_func   = func_type'(req_tuser);
   assign q          = node_rec_type'(ram_rdata);

   assign bit_b    = key_ff[lvl_ff];
   assign lim_b    = lim_ff[lvl_ff];
   assign first    = (func_ff == FN_MAX) ? ~bit_b : bit_b;
   assign lvl_last = (lvl_ff == '0);
   assign c_b      = child_of(rec_ff, bit_b);
   assign c_nb     = child_of(rec_ff, ~bit_b);
   assign c_first  = child_of(rec_ff, first);
   assign c_alt    = child_of(rec_ff, ~first);
   // nodes still to allocate when the path breaks at this level
   assign need     = {1'b0, lvl_ff} + (LVL_W+1)'(1);
   assign alloc_ok = ({1'b0, free_ff} + (FREE_W+1)'(need)) <= (FREE_W+1)'(NODES);
   assign root_rec = '{zero_child: root_zero_ff, one_child: root_one_ff, tally: '0};
   assign new_rec  = '{zero_child: '0, one_child: '0, tally: TALLY_W'(1)};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               priority case (req_func)
                  FN_INSERT: state_in = (total_ff >= TALLY_W'(MAX_VALUES)) ? S_DONE : S_ICHK;
                  FN_ERASE:  state_in = S_ECHK;
                  FN_MAX,
                  FN_MIN:    state_in = (total_ff == '0) ? S_DONE : S_XEVAL;
                  FN_COUNT:  state_in = (total_ff == '0) ? S_DONE : S_CEVAL;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_ICHK: begin
            if (c_b == '0) begin
               state_in = alloc_ok ? S_IUPD : S_DONE;
            end else if (lvl_last) begin
               state_in = S_IUPD;
            end else begin
               state_in = S_ICHK_LD;
            end
         end
         S_ICHK_LD:  state_in = S_ICHK;
         S_IUPD:     state_in = (c_b == '0) ? S_IUPD_NEW : S_IUPD_LD;
         S_IUPD_NEW,
         S_IUPD_LD:  state_in = lvl_last ? S_DONE : S_IUPD;
         S_ECHK:     state_in = (c_b == '0) ? S_DONE : S_ECHK_LD;
         S_ECHK_LD: begin
            if (q.tally == '0) begin
               state_in = S_DONE;
            end else begin
               state_in = lvl_last ? S_EUPD : S_ECHK;
            end
         end
         S_EUPD:     state_in = S_EUPD_LD;
         S_EUPD_LD:  state_in = lvl_last ? S_DONE : S_EUPD;
         S_XEVAL: begin
            if (c_first != '0) begin
               state_in = S_XLD1;
            end else begin
               state_in = (c_alt == '0) ? S_DONE : S_XLD2;
            end
         end
         S_XLD1: begin
            if (q.tally != '0) begin
               state_in = lvl_last ? S_DONE : S_XEVAL;
            end else begin
               state_in = (c_alt == '0) ? S_DONE : S_XLD2;
            end
         end
         S_XLD2:     state_in = lvl_last ? S_DONE : S_XEVAL;
         S_CEVAL: begin
            if (lim_b) begin
               if (c_b != '0) begin
                  state_in = S_CLD_T;
               end else begin
                  state_in = (c_nb == '0) ? S_DONE : S_CLD_N;
               end
            end else begin
               state_in = (c_b == '0) ? S_DONE : S_CLD_N;
            end
         end
         S_CLD_T:    state_in = (c_nb == '0) ? S_DONE : S_CLD_N;
         S_CLD_N:    state_in = lvl_last ? S_DONE : S_CEVAL;
         S_DONE:     state_in = out_free ? S_IDLE : S_DONE;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      func_in      = func_ff;
      key_in       = key_ff;
      lim_in       = lim_ff;
      node_in      = node_ff;
      rec_in       = rec_ff;
      lvl_in       = lvl_ff;
      free_in      = free_ff;
      total_in     = total_ff;
      root_zero_in = root_zero_ff;
      root_one_in  = root_one_ff;
      ans_in       = ans_ff;
      cnt_in       = cnt_ff;
      stat_in      = stat_ff;
      ram_we       = 1'b0;
      ram_addr     = node_ff;
      ram_wdata    = rec_ff;
      out_load     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               func_in = req_func;
               key_in  = req_tdata[31:0];
               lim_in  = req_tdata[63:32];
               node_in = '0;
               rec_in  = root_rec;
               lvl_in  = LVL_W'(KEY_BITS - 1);
               ans_in  = '0;
               cnt_in  = '0;
               stat_in = ST_OK;
               priority case (req_func)
                  FN_INSERT: begin
                     if (total_ff >= TALLY_W'(MAX_VALUES)) begin
                        stat_in = ST_FULL;
                     end
                  end
                  FN_MAX,
                  FN_MIN,
                  FN_COUNT: begin
                     if (total_ff == '0) begin
                        stat_in = ST_EMPTY;
                     end
                  end
                  FN_CLEAR: begin
                     root_zero_in = '0;
                     root_one_in  = '0;
                     free_in      = FREE_W'(1);
                     total_in     = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_ICHK: begin
            if (c_b == '0 || lvl_last) begin
               if (c_b == '0 && !alloc_ok) begin
                  stat_in = ST_FULL;
               end else begin
                  // room confirmed: start the update walk at the root
                  node_in = '0;
                  rec_in  = root_rec;
                  lvl_in  = LVL_W'(KEY_BITS - 1);
               end
            end else begin
               ram_addr = c_b;
               node_in  = c_b;
            end
         end
         S_ICHK_LD: begin
            rec_in = q;
            lvl_in = lvl_ff - LVL_W'(1);
         end
         S_IUPD: begin
            if (c_b == '0) begin
               // link a fresh node into the parent
               rec_in = set_child(rec_ff, bit_b, free_ff[NODE_W-1:0]);
               if (node_ff == '0) begin
                  if (bit_b) begin
                     root_one_in = free_ff[NODE_W-1:0];
                  end else begin
                     root_zero_in = free_ff[NODE_W-1:0];
                  end
               end else begin
                  ram_we    = 1'b1;
                  ram_addr  = node_ff;
                  ram_wdata = set_child(rec_ff, bit_b, free_ff[NODE_W-1:0]);
               end
               node_in = free_ff[NODE_W-1:0];
               free_in = free_ff + FREE_W'(1);
            end else begin
               ram_addr = c_b;
               node_in  = c_b;
            end
         end
         S_IUPD_NEW: begin
            ram_we    = 1'b1;
            ram_addr  = node_ff;
            ram_wdata = new_rec;
            rec_in    = new_rec;
            if (lvl_last) begin
               total_in = total_ff + TALLY_W'(1);
            end else begin
               lvl_in = lvl_ff - LVL_W'(1);
            end
         end
         S_IUPD_LD: begin
            rec_in       = q;
            rec_in.tally = q.tally + TALLY_W'(1);
            ram_we       = 1'b1;
            ram_addr     = node_ff;
            ram_wdata    = rec_in;
            if (lvl_last) begin
               total_in = total_ff + TALLY_W'(1);
            end else begin
               lvl_in = lvl_ff - LVL_W'(1);
            end
         end
         S_ECHK: begin
            if (c_b == '0) begin
               stat_in = ST_ABSENT;
            end else begin
               ram_addr = c_b;
               node_in  = c_b;
            end
         end
         S_ECHK_LD: begin
            if (q.tally == '0) begin
               stat_in = ST_ABSENT;
            end else if (lvl_last) begin
               node_in = '0;
               rec_in  = root_rec;
               lvl_in  = LVL_W'(KEY_BITS - 1);
            end else begin
               rec_in = q;
               lvl_in = lvl_ff - LVL_W'(1);
            end
         end
         S_EUPD: begin
            ram_addr = c_b;
            node_in  = c_b;
         end
         S_EUPD_LD: begin
            rec_in       = q;
            rec_in.tally = q.tally - TALLY_W'(1);
            ram_we       = 1'b1;
            ram_addr     = node_ff;
            ram_wdata    = rec_in;
            if (lvl_last) begin
               total_in = total_ff - TALLY_W'(1);
            end else begin
               lvl_in = lvl_ff - LVL_W'(1);
            end
         end
         S_XEVAL: begin
            if (c_first != '0) begin
               ram_addr = c_first;
            end else begin
               if (func_ff == FN_MIN) begin
                  ans_in[lvl_ff] = 1'b1;
               end
               ram_addr = c_alt;
            end
         end
         S_XLD1: begin
            if (q.tally != '0) begin
               if (func_ff == FN_MAX) begin
                  ans_in[lvl_ff] = 1'b1;
               end
               rec_in = q;
               if (!lvl_last) begin
                  lvl_in = lvl_ff - LVL_W'(1);
               end
            end else begin
               // preferred branch is dead: take the other one
               if (func_ff == FN_MIN) begin
                  ans_in[lvl_ff] = 1'b1;
               end
               ram_addr = c_alt;
            end
         end
         S_XLD2: begin
            rec_in = q;
            if (!lvl_last) begin
               lvl_in = lvl_ff - LVL_W'(1);
            end
         end
         S_CEVAL: begin
            if (lim_b) begin
               ram_addr = (c_b != '0) ? c_b : c_nb;
            end else begin
               ram_addr = c_b;
            end
         end
         S_CLD_T: begin
            cnt_in   = cnt_ff + q.tally;
            ram_addr = c_nb;
         end
         S_CLD_N: begin
            rec_in = q;
            if (!lvl_last) begin
               lvl_in = lvl_ff - LVL_W'(1);
            end
         end
         S_DONE: begin
            out_load = out_free;
         end
         default: ;
      endcase
   end

   assign out_payload = '{status: stat_ff, xor_result: ans_ff, match_count: cnt_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         free_ff      <= FREE_W'(1);
         total_ff     <= '0;
         root_zero_ff <= '0;
         root_one_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         free_ff      <= free_in;
         total_ff     <= total_in;
         root_zero_ff <= root_zero_in;
         root_one_ff  <= root_one_in;
      end
      func_ff <= func_in;
      key_ff  <= key_in;
      lim_ff  <= lim_in;
      node_ff <= node_in;
      rec_ff  <= rec_in;
      lvl_ff  <= lvl_in;
      ans_ff  <= ans_in;
      cnt_ff  <= cnt_in;
      stat_ff <= stat_in;
   end

   bxq_ram #(
      .WIDTH ($bits(node_rec_type)),
      .DEPTH (NODES)
   ) u_node_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   bxq_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .payload    (out_payload),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
